[hdl/bmp24_pkg.sv]
package bmp24_pkg;

  // Largest accepted image dimension in pixels.
  localparam logic [31:0] MAX_DIM = 32'd4096;
  localparam int DIM_W = 13;

  // Header layout: 14-byte file header plus 40-byte info header.
  localparam logic [31:0] HDR_LEN  = 32'd54;
  localparam logic [31:0] HDR_LAST = 32'd53;

  // Byte positions at which a little-endian header field is complete.
  localparam logic [31:0] POS_SIGNATURE   = 32'd1;
  localparam logic [31:0] POS_DATA_OFFSET = 32'd13;
  localparam logic [31:0] POS_WIDTH       = 32'd21;
  localparam logic [31:0] POS_HEIGHT      = 32'd25;
  localparam logic [31:0] POS_BPP         = 32'd29;
  localparam logic [31:0] POS_COMPRESSION = 32'd33;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_BPP       = 16'd24;

  // Result beat layout: red, green, blue, width, height, then zero fill.
  localparam int STATUS_W   = 3;
  localparam int FIELDS_W   = 3 * 8 + 2 * DIM_W;
  localparam int OUT_DATA_W = ((FIELDS_W + 7) / 8) * 8;
  localparam int FILL_W     = OUT_DATA_W - FIELDS_W;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PIXEL      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HEADER_OK  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIG    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_BPP    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COMPRESSED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd5;

  // Header fault flag bits.
  localparam int FLT_SIG  = 0;
  localparam int FLT_BPP  = 1;
  localparam int FLT_COMP = 2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic                last_pixel;
  } result_t;

endpackage

[hdl/bmp24_parse.sv]
module bmp24_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  output bmp24_pkg::result_t res
);
  import bmp24_pkg::*;

  phase_t           parse_phase, parse_phase_next;
  logic [31:0]      byte_position, byte_position_next;
  logic [31:0]      header_shift, header_shift_next;
  logic [31:0]      pixel_data_start, pixel_data_start_next;
  logic [DIM_W-1:0] width_store, width_store_next;
  logic [DIM_W-1:0] height_store, height_store_next;
  logic [DIM_W-1:0] column_count, column_count_next;
  logic [DIM_W-1:0] row_count, row_count_next;
  logic [1:0]       byte_in_pixel, byte_in_pixel_next;
  logic [15:0]      held_blue_green, held_blue_green_next;
  logic [1:0]       padding_left, padding_left_next;
  logic [2:0]       fault_flags, fault_flags_next;
  logic [1:0]       size_fault, size_fault_next;

  phase_t           cur_phase;
  logic [31:0]      hdr_pos;
  logic [31:0]      shifted;
  logic [2:0]       hdr_faults;
  logic [1:0]       cur_size;
  logic             hdr_last;
  logic [31:0]      skip_pos;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;
  logic             row_done;
  logic             image_done;
  logic             empty_image;
  logic [1:0]       pad_dec;

  // A first byte restarts the header parse on the same beat.
  assign cur_phase = first_byte ? PH_HEADER : parse_phase;
  assign hdr_pos   = first_byte ? '0 : byte_position;
  assign cur_size  = first_byte ? '0 : size_fault;
  assign shifted   = {data_byte, (first_byte ? 24'd0 : header_shift[31:8])};
  assign hdr_last  = (hdr_pos == HDR_LAST);

  // Header checks on the field that completes with this byte.
  always_comb begin
    hdr_faults = first_byte ? '0 : fault_flags;
    if (hdr_pos == POS_SIGNATURE && shifted[31:16] != BMP_SIGNATURE) begin
      hdr_faults[FLT_SIG] = 1'b1;
    end
    if (hdr_pos == POS_BPP && shifted[31:16] != BMP_BPP) begin
      hdr_faults[FLT_BPP] = 1'b1;
    end
    if (hdr_pos == POS_COMPRESSION && shifted != '0) begin
      hdr_faults[FLT_COMP] = 1'b1;
    end
  end

  // Counter helpers; the skip position saturates instead of wrapping.
  assign skip_pos    = (&byte_position) ? byte_position : byte_position + 32'd1;
  assign col_inc     = column_count + 1'b1;
  assign row_inc     = row_count + 1'b1;
  assign row_done    = (col_inc >= width_store);
  assign image_done  = (row_inc >= height_store);
  assign empty_image = (width_store == '0) || (height_store == '0);
  assign pad_dec     = padding_left - 2'd1;

  // Next-state logic.
  always_comb begin
    parse_phase_next      = parse_phase;
    byte_position_next    = byte_position;
    header_shift_next     = header_shift;
    pixel_data_start_next = pixel_data_start;
    width_store_next      = width_store;
    height_store_next     = height_store;
    column_count_next     = column_count;
    row_count_next        = row_count;
    byte_in_pixel_next    = byte_in_pixel;
    held_blue_green_next  = held_blue_green;
    padding_left_next     = padding_left;
    fault_flags_next      = fault_flags;
    size_fault_next       = size_fault;
    if (step) begin
      unique case (cur_phase)
        PH_HEADER: begin
          parse_phase_next   = PH_HEADER;
          header_shift_next  = shifted;
          byte_position_next = hdr_pos + 32'd1;
          fault_flags_next   = hdr_faults;
          size_fault_next    = cur_size;
          if (hdr_pos == POS_DATA_OFFSET) begin
            pixel_data_start_next = (shifted < HDR_LEN) ? HDR_LEN : shifted;
          end
          if (hdr_pos == POS_WIDTH) begin
            width_store_next   = shifted[DIM_W-1:0];
            size_fault_next[0] = (shifted > MAX_DIM);
          end
          if (hdr_pos == POS_HEIGHT) begin
            height_store_next  = shifted[DIM_W-1:0];
            size_fault_next[1] = (shifted > MAX_DIM);
          end
          if (hdr_last) begin
            if (hdr_faults != '0 || cur_size != '0) begin
              parse_phase_next = PH_DONE;
            end else if (HDR_LEN >= pixel_data_start) begin
              row_count_next = '0;
              if (empty_image) begin
                parse_phase_next = PH_DONE;
              end else begin
                column_count_next  = '0;
                byte_in_pixel_next = '0;
                parse_phase_next   = PH_PIXEL;
              end
            end else begin
              parse_phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          byte_position_next = skip_pos;
          if (skip_pos >= pixel_data_start) begin
            row_count_next = '0;
            if (empty_image) begin
              parse_phase_next = PH_DONE;
            end else begin
              column_count_next  = '0;
              byte_in_pixel_next = '0;
              parse_phase_next   = PH_PIXEL;
            end
          end
        end
        PH_PIXEL: begin
          case (byte_in_pixel)
            2'd0: begin
              held_blue_green_next = {8'd0, data_byte};
              byte_in_pixel_next   = 2'd1;
            end
            2'd1: begin
              held_blue_green_next[15:8] = data_byte;
              byte_in_pixel_next         = 2'd2;
            end
            default: begin
              byte_in_pixel_next = '0;
              column_count_next  = col_inc;
              if (row_done) begin
                row_count_next = row_inc;
                if (image_done) begin
                  parse_phase_next = PH_DONE;
                end else if (width_store[1:0] != 2'd0) begin
                  padding_left_next = width_store[1:0];
                  parse_phase_next  = PH_PAD;
                end else begin
                  padding_left_next = '0;
                  column_count_next = '0;
                end
              end
            end
          endcase
        end
        PH_PAD: begin
          padding_left_next = pad_dec;
          if (pad_dec == 2'd0) begin
            column_count_next  = '0;
            byte_in_pixel_next = '0;
            parse_phase_next   = PH_PIXEL;
          end
        end
        default: begin
          parse_phase_next = parse_phase;
        end
      endcase
    end
  end

  // Result for the byte in flight.
  always_comb begin
    res = '0;
    if (step) begin
      unique case (cur_phase)
        PH_HEADER: begin
          if (hdr_last) begin
            res.valid = 1'b1;
            if (hdr_faults[FLT_SIG]) begin
              res.status = ST_BAD_SIG;
            end else if (hdr_faults[FLT_BPP]) begin
              res.status = ST_BAD_BPP;
            end else if (hdr_faults[FLT_COMP]) begin
              res.status = ST_COMPRESSED;
            end else if (cur_size != '0) begin
              res.status = ST_TOO_LARGE;
            end else begin
              res.status       = ST_HEADER_OK;
              res.image_width  = width_store;
              res.image_height = height_store;
            end
          end
        end
        PH_PIXEL: begin
          if (byte_in_pixel != 2'd0 && byte_in_pixel != 2'd1) begin
            res.valid      = 1'b1;
            res.status     = ST_PIXEL;
            res.red        = data_byte;
            res.green      = held_blue_green[15:8];
            res.blue       = held_blue_green[7:0];
            res.last_pixel = row_done && image_done;
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_IDLE;
      byte_position    <= '0;
      header_shift     <= '0;
      pixel_data_start <= '0;
      width_store      <= '0;
      height_store     <= '0;
      column_count     <= '0;
      row_count        <= '0;
      byte_in_pixel    <= '0;
      held_blue_green  <= '0;
      padding_left     <= '0;
      fault_flags      <= '0;
      size_fault       <= '0;
    end else begin
      parse_phase      <= parse_phase_next;
      byte_position    <= byte_position_next;
      header_shift     <= header_shift_next;
      pixel_data_start <= pixel_data_start_next;
      width_store      <= width_store_next;
      height_store     <= height_store_next;
      column_count     <= column_count_next;
      row_count        <= row_count_next;
      byte_in_pixel    <= byte_in_pixel_next;
      held_blue_green  <= held_blue_green_next;
      padding_left     <= padding_left_next;
      fault_flags      <= fault_flags_next;
      size_fault       <= size_fault_next;
    end
  end

endmodule

[hdl/bmp24_stream_decoder.sv]
// A byte is held in the input register, then its result beat in the result register.
// One byte per cycle unless stalled; each byte costs only counter and compare updates.
// A stalled result beat lets one more byte into the input register, then stops input.
// Reset (rst, synchronous, active high) empties both registers and leaves the
// parser idle until a byte marked as the first of a file arrives.
module bmp24_stream_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // data_byte
  input  logic                             s_tuser,  // first_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // red, green, blue, image_width, image_height, zero fill
  output logic [bmp24_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [bmp24_pkg::STATUS_W-1:0]   m_tuser,  // status
  output logic                             m_tlast   // last_pixel
);
  import bmp24_pkg::*;

  logic    in_valid;
  logic [7:0] in_byte;
  logic    in_first;
  logic    advance;
  logic    step;
  result_t res;

  // The result register frees up when empty or when its beat is taken.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  bmp24_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_byte),
    .first_byte (in_first),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tuser <= res.status;
      m_tdata <= {{FILL_W{1'b0}}, res.image_height, res.image_width,
                  res.blue, res.green, res.red};
      m_tlast <= res.last_pixel;
    end
  end

endmodule

[hdl/bmp24_checker.sv]
module bmp24_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [bmp24_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [bmp24_pkg::STATUS_W-1:0]   m_tuser,
  input logic                             m_tlast
);
  import bmp24_pkg::*;

  // A stalled result beat keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result beat changed");

  // Only a pixel beat can close the image.
  a_last_pixel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == ST_PIXEL)
    else $error("last marker on a non-pixel beat");

  // Status beats carry no color, and only an accepted header carries a size.
  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_PIXEL |-> m_tdata[23:0] == '0)
    else $error("color bits set on a status beat");

  a_size_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_HEADER_OK |-> m_tdata[OUT_DATA_W-1:24] == '0)
    else $error("size bits set outside a header beat");

  // The status code always names a defined outcome.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ST_TOO_LARGE)
    else $error("undefined status code");

endmodule

bind bmp24_stream_decoder bmp24_checker u_checker (.*);
